// ===== sv/ptsa_pkg.sv =====
// Shared constants for the pixel to scattering angles block.
// Holds default parameter values, register codes, reset values and the arctangent table.
package ptsa_pkg;

   localparam int INDEX_BITS_DEF    = 12;
   localparam int ANGLE_BITS_DEF    = 16;
   localparam int CORDIC_STAGES_DEF = 18;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X        = 3'd0,
      CSR_CENTER_Y        = 3'd1,
      CSR_PIXEL_WIDTH     = 3'd2,
      CSR_PIXEL_HEIGHT    = 3'd3,
      CSR_SAMPLE_DISTANCE = 3'd4
   } csr_index_type;

   localparam logic signed [16:0] CENTER_RST   = 17'sd0;
   localparam logic [19:0]        PIXEL_RST    = 20'd44032;
   localparam logic [31:0]        DISTANCE_RST = 32'd256000000;

   // angle accumulator: 2^32 per turn
   localparam int ZW = 34;
   localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;

   // inverse CORDIC gain in Q30
   localparam logic [29:0] GAIN_Q30 = 30'd652032874;

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

endpackage

// ===== sv/ptsa_cordic.sv =====
// Pipelined CORDIC vectoring unit: one pre-rotation stage, then one stage per iteration.
// Depends on ptsa_pkg for the arctangent table and the angle format.
module ptsa_cordic #(
   parameter int W  = 44,
   parameter int NS = 18,
   parameter int SW = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic signed [W-1:0]          in_x,
   input  logic signed [W-1:0]          in_y,
   input  logic [SW-1:0]                in_side,
   output logic                         out_valid,
   output logic signed [W-1:0]          out_mag,
   output logic signed [ptsa_pkg::ZW-1:0] out_angle,
   output logic [SW-1:0]                out_side
);
   import ptsa_pkg::*;

   logic signed [W-1:0]  x_ff [NS+1];
   logic signed [W-1:0]  y_ff [NS+1];
   logic signed [ZW-1:0] z_ff [NS+1];
   logic                 zero_ff [NS+1];
   logic                 v_ff [NS+1];
   logic [SW-1:0]        side_ff [NS+1];

   logic signed [W-1:0]  x_in, y_in;
   logic signed [ZW-1:0] z_in;

   // fold left half-plane vectors by a quarter turn
   always_comb begin
      x_in = in_x;
      y_in = in_y;
      z_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x_in = in_y;
            y_in = -in_x;
            z_in = QUARTER_TURN;
         end else begin
            x_in = -in_y;
            y_in = in_x;
            z_in = -QUARTER_TURN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         z_ff[0]    <= z_in;
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_iter
      logic signed [W-1:0]  x_in_k, y_in_k;
      logic signed [ZW-1:0] z_in_k, a_k;
      always_comb begin
         a_k = ZW'(signed'({1'b0, ATAN_TAB[k]}));
         if (y_ff[k] >= 0) begin
            x_in_k = x_ff[k] + (y_ff[k] >>> k);
            y_in_k = y_ff[k] - (x_ff[k] >>> k);
            z_in_k = z_ff[k] + a_k;
         end else begin
            x_in_k = x_ff[k] - (y_ff[k] >>> k);
            y_in_k = y_ff[k] + (x_ff[k] >>> k);
            z_in_k = z_ff[k] - a_k;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
         if (en) begin
            x_ff[k+1]    <= x_in_k;
            y_ff[k+1]    <= y_in_k;
            z_ff[k+1]    <= z_in_k;
            zero_ff[k+1] <= zero_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // zero vector gives angle and magnitude zero
   assign out_valid = v_ff[NS];
   assign out_mag   = zero_ff[NS] ? '0 : x_ff[NS];
   assign out_angle = zero_ff[NS] ? '0 : z_ff[NS];
   assign out_side  = side_ff[NS];

endmodule

// ===== sv/ptsa_gain.sv =====
// Two-stage removal of the CORDIC gain from a magnitude, split into high and low products.
// Depends on ptsa_pkg for the Q30 gain constant.
module ptsa_gain #(
   parameter int W  = 44,
   parameter int SW = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [W-1:0] in_mag,
   input  logic [SW-1:0]       in_side,
   output logic                out_valid,
   output logic signed [W-1:0] out_len,
   output logic [SW-1:0]       out_side
);
   import ptsa_pkg::*;

   localparam int HW = W - 16;

   logic [W-2:0]      u;
   logic [HW+29:0]    hi_ff;
   logic [44:0]       lo_ff;
   logic              v1_ff, v2_ff;
   logic [SW-1:0]     s1_ff, s2_ff;
   logic [HW+30:0]    sum;
   logic signed [W-1:0] len_ff;

   assign u = (in_mag > 0) ? in_mag[W-2:0] : '0;

   assign sum = {1'b0, hi_ff} + (HW+31)'(lo_ff >> 15);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         hi_ff  <= u[W-2:15] * GAIN_Q30;
         lo_ff  <= u[14:0] * GAIN_Q30;
         s1_ff  <= in_side;
         len_ff <= W'(sum >> 15);
         s2_ff  <= s1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_len   = len_ff;
   assign out_side  = s2_ff;

endmodule

// ===== sv/pixel_to_scattering_angles.sv =====
// Top level of the detector pixel to scattering angles pipeline.
// Depends on ptsa_pkg, ptsa_cordic and ptsa_gain.
//
// Usage:
//   Feed one pixel word per cycle on req_ (column and row); each word yields one
//   rsp_ word holding the in-plane angle and the exit angle as fractions of pi.
//   Program the beam center, pixel sizes and sample distance through csr_ while
//   the pipeline is empty; writes take effect at the next clock edge.
// Throughput: one word per cycle while the output is not stalled. The pipeline
//   has 2*CORDIC_STAGES + 7 register stages: offset, multiply, two CORDIC
//   passes of one
//   pre-rotation plus CORDIC_STAGES stages each, two gain stages and the
//   output register.
// Stall: the whole pipeline holds while rsp_tvalid is high and rsp_tready low;
//   req_tready drops in that case and nothing is lost or repeated. The output
//   register lets a new word enter in the same cycle a result is taken.
// Reset: clears all valid bits and loads the default geometry registers.
module pixel_to_scattering_angles #(
   parameter int INDEX_BITS    = ptsa_pkg::INDEX_BITS_DEF,
   parameter int ANGLE_BITS    = ptsa_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STAGES = ptsa_pkg::CORDIC_STAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // column, row
   input  logic [((2*INDEX_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // in_plane_angle, exit_angle
   output logic [((2*ANGLE_BITS+7)/8)*8-1:0]  rsp_tdata,
   input  logic                               csr_we,
   input  logic [ptsa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ptsa_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ptsa_pkg::*;

   localparam int NS  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int DW  = ((INDEX_BITS + 4 > 16) ? INDEX_BITS + 4 : 16) + 2;
   localparam int XW  = DW + 21;
   localparam int CW  = ((XW + 1 > 37) ? XW + 1 : 37) + 4;
   localparam int SH  = 31 - ANGLE_BITS;
   localparam int RW  = ((2*ANGLE_BITS+7)/8)*8;

   // geometry registers
   logic signed [16:0] center_x_ff, center_y_ff;
   logic [19:0]        pixel_width_ff, pixel_height_ff;
   logic [31:0]        sample_distance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff        <= CENTER_RST;
         center_y_ff        <= CENTER_RST;
         pixel_width_ff     <= PIXEL_RST;
         pixel_height_ff    <= PIXEL_RST;
         sample_distance_ff <= DISTANCE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:        center_x_ff        <= csr_wdata[16:0];
            CSR_CENTER_Y:        center_y_ff        <= csr_wdata[16:0];
            CSR_PIXEL_WIDTH:     pixel_width_ff     <= csr_wdata[19:0];
            CSR_PIXEL_HEIGHT:    pixel_height_ff    <= csr_wdata[19:0];
            CSR_SAMPLE_DISTANCE: sample_distance_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance everything unless the output word is stuck
   logic en;
   logic rsp_valid_ff;
   logic [ANGLE_BITS-1:0] theta_out_ff, alpha_out_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // stage 1: offsets from the beam center in 1/16 pixel
   logic [INDEX_BITS-1:0] col, row;
   logic signed [DW-1:0]  dx_ff, dy_ff;
   logic                  v1_ff, v2_ff;
   logic signed [XW-1:0]  x_ff, y_ff;

   assign col = req_tdata[INDEX_BITS-1:0];
   assign row = req_tdata[2*INDEX_BITS-1:INDEX_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         dx_ff <= DW'(signed'({1'b0, col, 4'b0000})) - DW'(center_x_ff);
         dy_ff <= DW'(signed'({1'b0, row, 4'b0000})) - DW'(center_y_ff);
         // stage 2: scale by the pixel size
         x_ff  <= XW'(dx_ff * signed'({1'b0, pixel_width_ff}));
         y_ff  <= XW'(dy_ff * signed'({1'b0, pixel_height_ff}));
      end
   end

   // first pass: theta = atan2(d, x), magnitude l
   logic                 c1_valid;
   logic signed [CW-1:0] c1_mag;
   logic signed [ZW-1:0] c1_angle;
   logic signed [XW-1:0] c1_y;

   ptsa_cordic #(.W(CW), .NS(NS), .SW(XW)) u_pass1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_x      (CW'(x_ff)),
      .in_y      (CW'(signed'({1'b0, sample_distance_ff, 4'b0000}))),
      .in_side   (y_ff),
      .out_valid (c1_valid),
      .out_mag   (c1_mag),
      .out_angle (c1_angle),
      .out_side  (c1_y)
   );

   // round and saturate an angle to the output scale
   function automatic logic [ANGLE_BITS-1:0] to_angle(input logic signed [ZW-1:0] z);
      logic [ZW-1:0] r;
      r = '0;
      if (z > 0) begin
         r = (ZW'(z) + (ZW'(1) << (SH-1))) >> SH;
      end
      if (r > ZW'((ZW'(1) << ANGLE_BITS) - 1)) begin
         r = ZW'((ZW'(1) << ANGLE_BITS) - 1);
      end
      return r[ANGLE_BITS-1:0];
   endfunction

   logic                  g_valid;
   logic signed [CW-1:0]  g_len;
   logic [XW+ANGLE_BITS-1:0] g_side;

   ptsa_gain #(.W(CW), .SW(XW+ANGLE_BITS)) u_gain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c1_valid),
      .in_mag    (c1_mag),
      .in_side   ({to_angle(c1_angle), c1_y}),
      .out_valid (g_valid),
      .out_len   (g_len),
      .out_side  (g_side)
   );

   // second pass: alpha = atan2(l, y)
   logic                  c2_valid;
   logic signed [CW-1:0]  c2_mag;
   logic signed [ZW-1:0]  c2_angle;
   logic [ANGLE_BITS-1:0] c2_theta;

   ptsa_cordic #(.W(CW), .NS(NS), .SW(ANGLE_BITS)) u_pass2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid),
      .in_x      (CW'(signed'(g_side[XW-1:0]))),
      .in_y      (g_len),
      .in_side   (g_side[XW+ANGLE_BITS-1:XW]),
      .out_valid (c2_valid),
      .out_mag   (c2_mag),
      .out_angle (c2_angle),
      .out_side  (c2_theta)
   );

   // output register; drop the unused second magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= c2_valid && (c2_mag == c2_mag);
      end
      if (en) begin
         theta_out_ff <= c2_theta;
         alpha_out_ff <= to_angle(c2_angle);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RW'({alpha_out_ff, theta_out_ff});

endmodule
